@@ rtl/etcdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emissive triangle CDF builder package
// Shared types, operation codes and register constants of the light table.
// ----------------------------------------------------------------------------
package etcdf_pkg;

    // Input item kinds as they arrive on the request channel.
    localparam logic [1:0] KIND_CLEAR    = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_WEIGHT_RED   = 2'd0;
    localparam logic [1:0] REG_WEIGHT_GREEN = 2'd1;
    localparam logic [1:0] REG_WEIGHT_BLUE  = 2'd2;
    localparam logic [1:0] REG_MIN_AREA     = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] WEIGHT_RED_RESET   = 16'd13933;
    localparam logic [15:0] WEIGHT_GREEN_RESET = 16'd46871;
    localparam logic [15:0] WEIGHT_BLUE_RESET  = 16'd4732;
    localparam logic [47:0] MIN_AREA_RESET     = 48'd0;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef logic signed [24:0] edge_t;

    typedef struct packed {
        op_t         op;
        edge_t       e1x;
        edge_t       e1y;
        edge_t       e1z;
        edge_t       e2x;
        edge_t       e2y;
        edge_t       e2z;
        logic [47:0] emission;
        logic        emissive;
        logic [9:0]  slot;
    } item_t;

    typedef struct packed {
        logic [15:0] weight_red;
        logic [15:0] weight_green;
        logic [15:0] weight_blue;
        logic [47:0] min_area;
    } cfg_t;

    typedef struct packed {
        logic               accepted;
        logic               table_full;
        logic [9:0]         light_slot;
        logic [31:0]        triangle_number;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [47:0]        area;
        logic [32:0]        cumulative_fraction;
        logic [10:0]        light_count;
    } result_t;

endpackage

@@ rtl/etcdf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emissive triangle CDF builder front end
// Accepts requests, decodes the kind and forms the triangle edge vectors.
// ----------------------------------------------------------------------------
module etcdf_front (
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic signed [23:0]  vertex_a_x,
    input  logic signed [23:0]  vertex_a_y,
    input  logic signed [23:0]  vertex_a_z,
    input  logic signed [23:0]  vertex_b_x,
    input  logic signed [23:0]  vertex_b_y,
    input  logic signed [23:0]  vertex_b_z,
    input  logic signed [23:0]  vertex_c_x,
    input  logic signed [23:0]  vertex_c_y,
    input  logic signed [23:0]  vertex_c_z,
    input  logic [47:0]         emission_rgb,
    input  logic [9:0]          read_slot,
    input  logic                queue_full,
    output logic                push,
    output etcdf_pkg::item_t    entry
);

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        entry          = '0;
        entry.e1x      = 25'(vertex_b_x) - 25'(vertex_a_x);
        entry.e1y      = 25'(vertex_b_y) - 25'(vertex_a_y);
        entry.e1z      = 25'(vertex_b_z) - 25'(vertex_a_z);
        entry.e2x      = 25'(vertex_c_x) - 25'(vertex_a_x);
        entry.e2y      = 25'(vertex_c_y) - 25'(vertex_a_y);
        entry.e2z      = 25'(vertex_c_z) - 25'(vertex_a_z);
        entry.emission = emission_rgb;
        entry.emissive = (emission_rgb != 48'd0);
        entry.slot     = read_slot;
        unique case (kind)
            etcdf_pkg::KIND_CLEAR:    entry.op = etcdf_pkg::OP_CLEAR;
            etcdf_pkg::KIND_TRIANGLE: entry.op = etcdf_pkg::OP_TRIANGLE;
            etcdf_pkg::KIND_READ:     entry.op = etcdf_pkg::OP_READ;
            default:                  entry.op = etcdf_pkg::OP_NONE;
        endcase
    end

endmodule

@@ rtl/etcdf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emissive triangle CDF builder request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module etcdf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  etcdf_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output etcdf_pkg::item_t head_item
);

    etcdf_pkg::item_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/etcdf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emissive triangle CDF builder back end
// Sequencer with a shared multiplier, a bit-serial square root and dividers,
// the cumulative power table and the result register.
// ----------------------------------------------------------------------------
module etcdf_back #(
    parameter int MAX_LIGHTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  etcdf_pkg::cfg_t    cfg,
    input  logic               item_valid,
    input  etcdf_pkg::item_t   item,
    output logic               item_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output etcdf_pkg::result_t result
);

    localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CW = $clog2(MAX_LIGHTS + 1);

    localparam logic [1:0] PART_HH = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_LL = 2'd2;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_CROSS  = 11'b00000000010,
        ST_SQUARE = 11'b00000000100,
        ST_SQRT   = 11'b00000001000,
        ST_NORM   = 11'b00000010000,
        ST_LUM    = 11'b00000100000,
        ST_POWER  = 11'b00001000000,
        ST_COMMIT = 11'b00010000000,
        ST_READ   = 11'b00100000000,
        ST_FRAC   = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } state_t;

    // Order of the partial products of the three squares.
    function automatic logic [1:0] sq_comp(input logic [3:0] t);
        logic [1:0] r;
        case (t)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] sq_part(input logic [3:0] t);
        logic [1:0] r;
        case (t)
            4'd0, 4'd3, 4'd6: r = PART_HH;
            4'd1, 4'd4, 4'd7: r = PART_HL;
            default:          r = PART_LL;
        endcase
        return r;
    endfunction

    state_t              state_reg;
    logic [5:0]          step_reg;
    etcdf_pkg::item_t    item_reg;
    logic signed [50:0]  c_reg [3];
    logic [99:0]         s_reg;
    logic [53:0]         rem_reg;
    logic [49:0]         root_reg;
    logic [1:0]          comp_reg;
    logic [63:0]         num_reg;
    logic [63:0]         dsh_reg;
    logic [14:0]         q_reg;
    logic [33:0]         lum_reg;
    logic [81:0]         pow_reg;
    logic [64:0]         fr_reg;
    logic [31:0]         fq_reg;
    logic signed [51:0]  mul_reg;
    etcdf_pkg::result_t  work_reg;
    etcdf_pkg::result_t  out_reg;
    logic                out_valid_reg;
    logic [CW-1:0]       stored_reg;
    logic [31:0]         seen_reg;
    logic [63:0]         total_reg;
    logic [63:0]         table_mem [MAX_LIGHTS];
    logic [63:0]         rd_data_reg;

    logic signed [25:0]  mul_a;
    logic signed [25:0]  mul_b;
    logic [48:0]         mag_w [3];
    logic [48:0]         mag_sel;
    logic [1:0]          sq_c;
    logic [1:0]          sq_p;
    logic [1:0]          sq_p_prev;
    logic [3:0]          step_prev;
    logic [99:0]         sq_term;
    logic [47:0]         area_w;
    logic                keep_w;
    logic                full_w;
    logic [53:0]         rem_sh;
    logic [53:0]         trial;
    logic                sqrt_ge;
    logic                norm_ge;
    logic [14:0]         q_final;
    logic signed [15:0]  normal_w;
    logic [64:0]         fr_sh;
    logic                frac_ge;
    logic [64:0]         sum_wide;
    logic [63:0]         sum_sat;
    logic                read_ok;
    logic                mem_we;
    etcdf_pkg::result_t  work_init;
    etcdf_pkg::result_t  done_w;
    logic                done_go;

    assign item_pop  = (state_reg == ST_IDLE) && item_valid;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_w[i] = c_reg[i][50] ? 49'(-c_reg[i]) : 49'(c_reg[i]);
        end
    end

    assign step_prev = step_reg[3:0] - 4'd1;
    assign sq_c      = sq_comp(step_reg[3:0]);
    assign sq_p      = sq_part(step_reg[3:0]);
    assign sq_p_prev = sq_part(step_prev);
    assign mag_sel   = mag_w[sq_c];

    // Shared 26 x 26 signed multiplier; operands chosen by the sequencer.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS)
        begin
            case (step_reg)
                6'd0:
                begin
                    mul_a = 26'($signed(item_reg.e1y));
                    mul_b = 26'($signed(item_reg.e2z));
                end
                6'd1:
                begin
                    mul_a = 26'($signed(item_reg.e1z));
                    mul_b = 26'($signed(item_reg.e2y));
                end
                6'd2:
                begin
                    mul_a = 26'($signed(item_reg.e1z));
                    mul_b = 26'($signed(item_reg.e2x));
                end
                6'd3:
                begin
                    mul_a = 26'($signed(item_reg.e1x));
                    mul_b = 26'($signed(item_reg.e2z));
                end
                6'd4:
                begin
                    mul_a = 26'($signed(item_reg.e1x));
                    mul_b = 26'($signed(item_reg.e2y));
                end
                6'd5:
                begin
                    mul_a = 26'($signed(item_reg.e1y));
                    mul_b = 26'($signed(item_reg.e2x));
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == ST_SQUARE)
        begin
            case (sq_p)
                PART_HH:
                begin
                    mul_a = $signed(26'(mag_sel[48:25]));
                    mul_b = $signed(26'(mag_sel[48:25]));
                end
                PART_HL:
                begin
                    mul_a = $signed(26'(mag_sel[48:25]));
                    mul_b = $signed(26'(mag_sel[24:0]));
                end
                default:
                begin
                    mul_a = $signed(26'(mag_sel[24:0]));
                    mul_b = $signed(26'(mag_sel[24:0]));
                end
            endcase
        end
        else if (state_reg == ST_LUM)
        begin
            case (step_reg)
                6'd0:
                begin
                    mul_a = $signed(26'(cfg.weight_red));
                    mul_b = $signed(26'(item_reg.emission[47:32]));
                end
                6'd1:
                begin
                    mul_a = $signed(26'(cfg.weight_green));
                    mul_b = $signed(26'(item_reg.emission[31:16]));
                end
                default:
                begin
                    mul_a = $signed(26'(cfg.weight_blue));
                    mul_b = $signed(26'(item_reg.emission[15:0]));
                end
            endcase
        end
        else if (state_reg == ST_POWER)
        begin
            mul_a = step_reg[1] ? $signed(26'(lum_reg[33:25]))
                                : $signed(26'(lum_reg[24:0]));
            mul_b = step_reg[0] ? $signed(26'(work_reg.area[47:25]))
                                : $signed(26'(work_reg.area[24:0]));
        end
    end

    always_comb
    begin
        case (sq_p_prev)
            PART_HH: sq_term = 100'($unsigned(mul_reg)) << 50;
            PART_HL: sq_term = 100'($unsigned(mul_reg)) << 26;
            default: sq_term = 100'($unsigned(mul_reg));
        endcase
    end

    // Result fields that are known when a request is taken from the queue.
    always_comb
    begin
        work_init = '0;
        if (item.op == etcdf_pkg::OP_TRIANGLE)
        begin
            work_init.triangle_number = seen_reg;
        end
        else if (item.op == etcdf_pkg::OP_READ)
        begin
            work_init.light_slot = item.slot;
        end
    end

    always_comb
    begin
        done_w             = work_reg;
        done_w.light_count = 11'(stored_reg);
    end

    assign done_go = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign area_w = root_reg[49] ? {48{1'b1}} : root_reg[48:1];
    assign keep_w = item_reg.emissive && (area_w > cfg.min_area);
    assign full_w = (32'(stored_reg) >= MAX_LIGHTS);

    // One root bit per cycle, two radicand bits brought down each time.
    assign rem_sh  = {rem_reg[51:0], s_reg[99:98]};
    assign trial   = 54'({root_reg, 2'b01});
    assign sqrt_ge = (rem_sh >= trial);

    assign norm_ge  = (num_reg >= dsh_reg);
    assign q_final  = {q_reg[13:0], norm_ge};
    assign normal_w = c_reg[comp_reg][50] ? -$signed(16'(q_final))
                                          : $signed(16'(q_final));

    assign fr_sh   = (step_reg == 6'd1) ? fr_reg : {fr_reg[63:0], 1'b0};
    assign frac_ge = (fr_sh >= 65'(total_reg));

    assign sum_wide = 65'(total_reg) + 65'(pow_reg[81:24]);
    assign sum_sat  = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];

    assign read_ok = (32'(item_reg.slot) < 32'(stored_reg))
                  && (32'(item_reg.slot) < MAX_LIGHTS);
    assign mem_we  = (state_reg == ST_COMMIT);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[IW'(stored_reg)] <= sum_sat;
        end
        rd_data_reg <= table_mem[IW'(item_reg.slot)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            stored_reg    <= '0;
            seen_reg      <= '0;
            total_reg     <= '0;
        end
        else
        begin
            mul_reg <= mul_a * mul_b;
            if (done_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg <= item;
                        step_reg <= '0;
                        work_reg <= work_init;
                        unique case (item.op)
                            etcdf_pkg::OP_CLEAR:
                            begin
                                stored_reg <= '0;
                                seen_reg   <= '0;
                                total_reg  <= '0;
                                state_reg  <= ST_DONE;
                            end
                            etcdf_pkg::OP_TRIANGLE:
                            begin
                                seen_reg  <= seen_reg + 32'd1;
                                state_reg <= ST_CROSS;
                            end
                            etcdf_pkg::OP_READ:
                            begin
                                state_reg <= ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_CROSS:
                begin
                    // Products arrive the cycle after issue: even ones start a
                    // component, odd ones are subtracted from it.
                    if (step_reg != 6'd0)
                    begin
                        if (!step_prev[0])
                        begin
                            c_reg[step_prev[2:1]] <= 51'(mul_reg);
                        end
                        else
                        begin
                            c_reg[step_prev[2:1]] <= c_reg[step_prev[2:1]]
                                                     - 51'(mul_reg);
                        end
                    end
                    if (step_reg == 6'd6)
                    begin
                        step_reg  <= '0;
                        s_reg     <= '0;
                        state_reg <= ST_SQUARE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end

                ST_SQUARE:
                begin
                    if (step_reg != 6'd0)
                    begin
                        s_reg <= s_reg + sq_term;
                    end
                    if (step_reg == 6'd9)
                    begin
                        step_reg  <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end

                ST_SQRT:
                begin
                    s_reg <= {s_reg[97:0], 2'b00};
                    if (sqrt_ge)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[48:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[48:0], 1'b0};
                    end
                    if (step_reg == 6'd49)
                    begin
                        step_reg  <= '0;
                        comp_reg  <= 2'd0;
                        state_reg <= ST_NORM;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end

                ST_NORM:
                begin
                    work_reg.area <= area_w;
                    if (root_reg == 50'd0 || (step_reg == 6'd15 && comp_reg == 2'd2))
                    begin
                        // The normal of a degenerate triangle stays zero.
                        if (root_reg != 50'd0)
                        begin
                            work_reg.normal_z <= normal_w;
                        end
                        step_reg <= '0;
                        lum_reg  <= '0;
                        if (keep_w && full_w)
                        begin
                            work_reg.table_full <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        else if (keep_w)
                        begin
                            state_reg <= ST_LUM;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                    else if (step_reg == 6'd0)
                    begin
                        num_reg  <= (64'(mag_w[comp_reg]) << 14) + 64'(root_reg[49:1]);
                        dsh_reg  <= 64'(root_reg) << 14;
                        q_reg    <= '0;
                        step_reg <= 6'd1;
                    end
                    else
                    begin
                        if (norm_ge)
                        begin
                            num_reg <= num_reg - dsh_reg;
                        end
                        dsh_reg <= dsh_reg >> 1;
                        q_reg   <= q_final;
                        if (step_reg == 6'd15)
                        begin
                            if (comp_reg == 2'd0)
                            begin
                                work_reg.normal_x <= normal_w;
                            end
                            else
                            begin
                                work_reg.normal_y <= normal_w;
                            end
                            comp_reg <= comp_reg + 2'd1;
                            step_reg <= '0;
                        end
                        else
                        begin
                            step_reg <= step_reg + 6'd1;
                        end
                    end
                end

                ST_LUM:
                begin
                    if (step_reg != 6'd0)
                    begin
                        lum_reg <= lum_reg + 34'($unsigned(mul_reg));
                    end
                    if (step_reg == 6'd3)
                    begin
                        step_reg  <= '0;
                        pow_reg   <= '0;
                        state_reg <= ST_POWER;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end

                ST_POWER:
                begin
                    if (step_reg != 6'd0)
                    begin
                        pow_reg <= pow_reg
                                 + ((82'($unsigned(mul_reg)) << (step_prev[1] ? 25 : 0))
                                    << (step_prev[0] ? 25 : 0));
                    end
                    if (step_reg == 6'd4)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_COMMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end

                ST_COMMIT:
                begin
                    total_reg           <= sum_sat;
                    work_reg.accepted   <= 1'b1;
                    work_reg.light_slot <= 10'(stored_reg);
                    stored_reg          <= stored_reg + CW'(1);
                    state_reg           <= ST_DONE;
                end

                ST_READ:
                begin
                    step_reg <= '0;
                    if (read_ok)
                    begin
                        work_reg.accepted <= 1'b1;
                        state_reg <= (total_reg != 64'd0) ? ST_FRAC : ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_FRAC:
                begin
                    if (step_reg == 6'd0)
                    begin
                        fr_reg   <= 65'(rd_data_reg);
                        fq_reg   <= '0;
                        step_reg <= 6'd1;
                    end
                    else
                    begin
                        fr_reg <= frac_ge ? (fr_sh - 65'(total_reg)) : fr_sh;
                        fq_reg <= {fq_reg[30:0], frac_ge};
                        if (step_reg == 6'd33)
                        begin
                            work_reg.cumulative_fraction <= {fq_reg, frac_ge};
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 6'd1;
                        end
                    end
                end

                ST_DONE:
                begin
                    if (done_go)
                    begin
                        out_reg   <= done_w;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/emissive_triangle_cdf_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emissive triangle CDF builder
// Builds a power-weighted cumulative light table from emissive triangles.
// ----------------------------------------------------------------------------
// One request is worked on at a time, with a two-entry queue in front and a
// result register behind. A clear or unused kind goes straight to the result,
// a valid read of a nonzero table runs the bit-serial fraction divider, and a
// triangle runs the cross product and squaring on the shared multiplier, the
// bit-serial square root and the three normal divisions (skipped when it is
// degenerate), then luminance, power and a commit of the entry when stored.
// The table itself has no clearing pass after reset.
module emissive_triangle_cdf_builder #(
    parameter int MAX_LIGHTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic signed [23:0]  vertex_a_x,
    input  logic signed [23:0]  vertex_a_y,
    input  logic signed [23:0]  vertex_a_z,
    input  logic signed [23:0]  vertex_b_x,
    input  logic signed [23:0]  vertex_b_y,
    input  logic signed [23:0]  vertex_b_z,
    input  logic signed [23:0]  vertex_c_x,
    input  logic signed [23:0]  vertex_c_y,
    input  logic signed [23:0]  vertex_c_z,
    input  logic [47:0]         emission_rgb,
    input  logic [9:0]          read_slot,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                accepted,
    output logic                table_full,
    output logic [9:0]          light_slot,
    output logic [31:0]         triangle_number,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic signed [15:0]  normal_z,
    output logic [47:0]         area,
    output logic [32:0]         cumulative_fraction,
    output logic [10:0]         light_count
);

    etcdf_pkg::cfg_t    cfg_reg;
    etcdf_pkg::item_t   push_item;
    etcdf_pkg::item_t   head_item;
    etcdf_pkg::result_t result;
    logic               push;
    logic               queue_full;
    logic               head_valid;
    logic               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_red   <= etcdf_pkg::WEIGHT_RED_RESET;
            cfg_reg.weight_green <= etcdf_pkg::WEIGHT_GREEN_RESET;
            cfg_reg.weight_blue  <= etcdf_pkg::WEIGHT_BLUE_RESET;
            cfg_reg.min_area     <= etcdf_pkg::MIN_AREA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                etcdf_pkg::REG_WEIGHT_RED:   cfg_reg.weight_red   <= cfg_data[15:0];
                etcdf_pkg::REG_WEIGHT_GREEN: cfg_reg.weight_green <= cfg_data[15:0];
                etcdf_pkg::REG_WEIGHT_BLUE:  cfg_reg.weight_blue  <= cfg_data[15:0];
                etcdf_pkg::REG_MIN_AREA:     cfg_reg.min_area     <= cfg_data;
            endcase
        end
    end

    etcdf_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .vertex_a_x   (vertex_a_x),
        .vertex_a_y   (vertex_a_y),
        .vertex_a_z   (vertex_a_z),
        .vertex_b_x   (vertex_b_x),
        .vertex_b_y   (vertex_b_y),
        .vertex_b_z   (vertex_b_z),
        .vertex_c_x   (vertex_c_x),
        .vertex_c_y   (vertex_c_y),
        .vertex_c_z   (vertex_c_z),
        .emission_rgb (emission_rgb),
        .read_slot    (read_slot),
        .queue_full   (queue_full),
        .push         (push),
        .entry        (push_item)
    );

    etcdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    etcdf_back #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (head_valid),
        .item       (head_item),
        .item_pop   (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign accepted            = result.accepted;
    assign table_full          = result.table_full;
    assign light_slot          = result.light_slot;
    assign triangle_number     = result.triangle_number;
    assign normal_x            = result.normal_x;
    assign normal_y            = result.normal_y;
    assign normal_z            = result.normal_z;
    assign area                = result.area;
    assign cumulative_fraction = result.cumulative_fraction;
    assign light_count         = result.light_count;

`ifndef SYNTHESIS
    // A triangle dropped for a full table is never also reported as stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> !accepted)
        else $error("table_full and accepted both set");

    // Only a valid read can carry a nonzero fraction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cumulative_fraction != 33'd0) |-> accepted)
        else $error("fraction on a request that was not accepted");

    // The normal divider never produces a component beyond unit length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384)
                   && (normal_y <= 16'sd16384) && (normal_y >= -16'sd16384)
                   && (normal_z <= 16'sd16384) && (normal_z >= -16'sd16384))
        else $error("normal component out of range");
`endif

endmodule
